### rtl/core/histeq_pkg.sv
package histeq_pkg;

  // Pixel and histogram geometry.
  localparam int PIX_W = 8;
  localparam int BINS  = 1 << PIX_W;

  // Largest number of pixels that the histogram counts before it saturates.
  localparam int MAX_PIXELS = 1048576;
  localparam int CNT_W      = $clog2(MAX_PIXELS + 1);

  // Divider sizing: the numerator is 510*cum + count, at most 511*count.
  localparam int NUM_W = CNT_W + 9;
  localparam int DEN_W = CNT_W + 1;
  localparam int Q_W   = PIX_W;

  // Item kinds.
  localparam logic [1:0] KIND_CLEAR = 2'd0;
  localparam logic [1:0] KIND_COUNT = 2'd1;
  localparam logic [1:0] KIND_MAP   = 2'd2;

  // Request to the shared divider.
  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  // Status from the shared divider.
  typedef struct packed {
    logic           done;
    logic [Q_W-1:0] quotient;
  } div_rsp_t;

endpackage

### rtl/core/histeq_div.sv
module histeq_div (
  input  logic                 clk,
  input  logic                 rst,
  input  histeq_pkg::div_req_t req,
  output histeq_pkg::div_rsp_t rsp
);
  import histeq_pkg::*;

  localparam int STEP_W = $clog2(Q_W + 1);

  logic [NUM_W-1:0]  rem;
  logic [NUM_W-1:0]  dsh;
  logic [Q_W-1:0]    quo;
  logic [STEP_W-1:0] steps;
  logic              done;
  logic [NUM_W:0]    diff;

  // One trial subtraction per cycle, most significant quotient bit first.
  assign diff = {1'b0, rem} - {1'b0, dsh};

  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
      done  <= 1'b0;
    end else if (req.start) begin
      rem   <= req.num;
      dsh   <= NUM_W'(req.den) << (Q_W - 1);
      quo   <= '0;
      steps <= STEP_W'(Q_W);
      done  <= 1'b0;
    end else if (steps != '0) begin
      if (!diff[NUM_W]) begin
        rem <= diff[NUM_W-1:0];
        quo <= {quo[Q_W-2:0], 1'b1};
      end else begin
        quo <= {quo[Q_W-2:0], 1'b0};
      end
      dsh   <= dsh >> 1;
      steps <= steps - 1'b1;
      done  <= (steps == STEP_W'(1));
    end else begin
      done <= 1'b0;
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

### rtl/core/histogram_equalizer_top.sv
// Two-pass 8-bit histogram equalizer. A clear transfer empties the histogram
// without holding off the next item; a count transfer adds a pixel to its bin
// by a read and a write back of the bin memory; a map transfer reads the
// equalized pixel from the lookup table, when the table is current, and passes
// it to the output register once that is free. The first map transfer after
// any clear or count rebuilds the table, walking the 256 bins and dividing each
// running sum in one shared restoring divider that gives one quotient bit a
// cycle; when no pixel has been counted, the divider is not used. in_stall is
// high while an item is being worked on; a finished result waits in the output
// register, and clear and count transfers are still taken meanwhile.
module histogram_equalizer_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  kind,
  input  logic [histeq_pkg::PIX_W-1:0] pixel_value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [histeq_pkg::PIX_W-1:0] mapped_pixel
);
  import histeq_pkg::*;

  localparam logic [3:0] ST_IDLE      = 4'd0;
  localparam logic [3:0] ST_CNT_WR    = 4'd1;
  localparam logic [3:0] ST_BLD_RD    = 4'd2;
  localparam logic [3:0] ST_BLD_ACC   = 4'd3;
  localparam logic [3:0] ST_BLD_DIVS  = 4'd4;
  localparam logic [3:0] ST_BLD_DIVW  = 4'd5;
  localparam logic [3:0] ST_BLD_WR    = 4'd6;
  localparam logic [3:0] ST_MAP_ISSUE = 4'd7;
  localparam logic [3:0] ST_MAP_RD    = 4'd8;

  logic [3:0]       st;
  logic [PIX_W-1:0] idx;
  logic [PIX_W-1:0] pix_reg;
  logic [CNT_W-1:0] cum;
  logic [CNT_W-1:0] pixel_count;
  logic             table_ready;
  logic [BINS-1:0]  bin_vld;

  logic [CNT_W-1:0] bin_mem [BINS];
  logic [PIX_W-1:0] map_mem [BINS];
  logic [CNT_W-1:0] bin_rd;
  logic             bin_rd_vld;
  logic [PIX_W-1:0] mt_rd;

  logic             in_take;
  logic             out_take;
  logic             slot_free;
  logic [PIX_W-1:0] bin_addr;
  logic             bin_ren;
  logic             bin_wen;
  logic [CNT_W-1:0] bin_cur;
  logic [PIX_W-1:0] mt_raddr;
  logic             mt_ren;
  logic             mt_wen;
  logic [PIX_W-1:0] mt_wdata;
  div_req_t         div_req;
  div_rsp_t         div_rsp;

  // Handshake decode.
  assign in_stall  = (st != ST_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_take  = out_valid && !out_stall;
  assign slot_free = !out_valid || !out_stall;

  // Bin memory port: one address serves the count update and the table walk.
  always_comb begin
    case (st)
      ST_IDLE:   bin_addr = pixel_value;
      ST_CNT_WR: bin_addr = pix_reg;
      default:   bin_addr = idx;
    endcase
  end

  assign bin_ren = (in_take && kind == KIND_COUNT) || (st == ST_BLD_RD);
  assign bin_wen = (st == ST_CNT_WR);
  assign bin_cur = bin_rd_vld ? bin_rd : '0;

  always_ff @(posedge clk) begin
    if (bin_wen) begin
      bin_mem[bin_addr] <= bin_cur + 1'b1;
    end
    if (bin_ren) begin
      bin_rd     <= bin_mem[bin_addr];
      bin_rd_vld <= bin_vld[bin_addr];
    end
  end

  // Lookup table port. Entry 0 and an empty histogram give zero.
  assign mt_raddr = (st == ST_IDLE) ? pixel_value : pix_reg;
  assign mt_ren   = (in_take && kind == KIND_MAP && table_ready) || (st == ST_MAP_ISSUE);
  assign mt_wen   = (st == ST_BLD_WR);
  assign mt_wdata = (idx == '0 || pixel_count == '0) ? '0 : div_rsp.quotient;

  always_ff @(posedge clk) begin
    if (mt_wen) begin
      map_mem[idx] <= mt_wdata;
    end
    if (mt_ren) begin
      mt_rd <= map_mem[mt_raddr];
    end
  end

  // Divider request: numerator 510*cum + count, denominator 2*count.
  assign div_req.start = (st == ST_BLD_DIVS) && (pixel_count != '0);
  assign div_req.num   = (NUM_W'(cum) << 9) - (NUM_W'(cum) << 1) + NUM_W'(pixel_count);
  assign div_req.den   = {pixel_count, 1'b0};

  histeq_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      st          <= ST_IDLE;
      idx         <= '0;
      cum         <= '0;
      pixel_count <= '0;
      table_ready <= 1'b0;
      bin_vld     <= '0;
    end else begin
      case (st)
        ST_IDLE: begin
          if (in_take) begin
            pix_reg <= pixel_value;
            case (kind)
              KIND_CLEAR: begin
                bin_vld     <= '0;
                pixel_count <= '0;
                table_ready <= 1'b0;
              end
              KIND_COUNT: begin
                table_ready <= 1'b0;
                if (pixel_count < CNT_W'(MAX_PIXELS)) begin
                  pixel_count <= pixel_count + 1'b1;
                  st          <= ST_CNT_WR;
                end
              end
              KIND_MAP: begin
                if (table_ready) begin
                  st <= ST_MAP_RD;
                end else begin
                  idx <= '0;
                  cum <= '0;
                  st  <= ST_BLD_RD;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_CNT_WR: begin
          bin_vld[pix_reg] <= 1'b1;
          st               <= ST_IDLE;
        end
        ST_BLD_RD: begin
          st <= ST_BLD_ACC;
        end
        ST_BLD_ACC: begin
          cum <= cum + bin_cur;
          st  <= ST_BLD_DIVS;
        end
        ST_BLD_DIVS: begin
          st <= (pixel_count == '0) ? ST_BLD_WR : ST_BLD_DIVW;
        end
        ST_BLD_DIVW: begin
          if (div_rsp.done) begin
            st <= ST_BLD_WR;
          end
        end
        ST_BLD_WR: begin
          if (idx == '1) begin
            table_ready <= 1'b1;
            st          <= ST_MAP_ISSUE;
          end else begin
            idx <= idx + 1'b1;
            st  <= ST_BLD_RD;
          end
        end
        ST_MAP_ISSUE: begin
          st <= ST_MAP_RD;
        end
        ST_MAP_RD: begin
          if (slot_free) begin
            st <= ST_IDLE;
          end
        end
        default: begin
          st <= ST_IDLE;
        end
      endcase
    end
  end

  // Output register: loaded when the mapped value is ready and the slot frees.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (st == ST_MAP_RD && slot_free) begin
      out_valid    <= 1'b1;
      mapped_pixel <= mt_rd;
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

endmodule

### rtl/core/histeq_chk.sv
module histeq_chk (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic [1:0]                   kind,
  input logic [histeq_pkg::PIX_W-1:0] pixel_value,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [histeq_pkg::PIX_W-1:0] mapped_pixel
);
  import histeq_pkg::*;

  // A result held back by the receiver stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(mapped_pixel))
    else $error("stalled result changed or vanished");

  // Clear and count transfers never produce a result.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && kind != KIND_MAP && !out_valid |=> !out_valid)
    else $error("result produced by a non-map transfer");

  // A map transfer keeps the block busy for at least the table read.
  a_map_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && kind == KIND_MAP |=> in_stall)
    else $error("map transfer did not hold off the next item");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind histogram_equalizer_top histeq_chk u_histeq_chk (.*);
